[rtl/prps_pkg.sv]
// Shared types, constants and control structures of the periodic request poll scheduler.
package prps_pkg;

  localparam int unsigned MAX_REQUESTS_DEF = 8;

  localparam int unsigned OPC_W    = 3;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned PERIOD_W = 16;

  // Smallest period a request may have; shorter periods are raised to it.
  localparam logic [PERIOD_W-1:0] PERIOD_FLOOR = 16'd5;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 3'd0,
    OP_TICK   = 3'd1,
    OP_TXDONE = 3'd2,
    OP_STOP   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_START  = 3'd5
  } opcode_t;

  localparam logic EV_SENT   = 1'b0;
  localparam logic EV_REJECT = 1'b1;

  // One request as it sits in the priority list.
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [PERIOD_W-1:0] period;
    logic                reply_flag;
    logic [PERIOD_W-1:0] countdown;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_new;
    logic count_inc;
    logic count_zero;
    logic queue_clear;
    logic run_set;
    logic run_clr;
    logic ready_set;
    logic p_zero;
    logic p_dec;
    logic p_inc;
    logic rd_p;
    logic rd_pm1;
    logic rd_fifo;
    logic wr_new;
    logic wr_shift;
    logic wr_reload;
    logic wr_tick;
    logic fifo_rd;
    logic out_tx;
    logic out_rej;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic p_zero;
    logic p_at_count;
    logic full;
    logic shift_go;
    logic can_tx;
    logic running;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/prps_in_if.sv]
// Input channel of the scheduler: one command item per transfer.
interface prps_in_if;
  logic                          valid;
  logic                          ready;
  logic [prps_pkg::OPC_W-1:0]    opcode;
  logic [prps_pkg::TAG_W-1:0]    request_tag;
  logic [prps_pkg::PERIOD_W-1:0] period_ticks;
  logic                          reply_flag;

  modport source (output valid, opcode, request_tag, period_ticks, reply_flag, input ready);
  modport sink (input valid, opcode, request_tag, period_ticks, reply_flag, output ready);
endinterface

[rtl/prps_out_if.sv]
// Result channel of the scheduler: one event per transfer.
interface prps_out_if;
  logic                       valid;
  logic                       ready;
  logic                       event_kind;
  logic [prps_pkg::TAG_W-1:0] sent_tag;
  logic                       sent_reply_flag;

  modport source (output valid, event_kind, sent_tag, sent_reply_flag, input ready);
  modport sink (input valid, event_kind, sent_tag, sent_reply_flag, output ready);
endinterface

[rtl/prps_dp.sv]
// Datapath: request list memory, pending queue, counters and the output register.
module prps_dp #(
  parameter int unsigned MAX_REQUESTS = prps_pkg::MAX_REQUESTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prps_pkg::dp_cmd_t             cmd,
  output prps_pkg::dp_sts_t             sts,
  input  logic [prps_pkg::TAG_W-1:0]    new_tag,
  input  logic [prps_pkg::PERIOD_W-1:0] new_period,
  input  logic                          new_wait,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_event_kind,
  output logic [prps_pkg::TAG_W-1:0]    out_sent_tag,
  output logic                          out_sent_reply_flag
);
  import prps_pkg::*;

  localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REQUESTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_REQUESTS - 1);
  localparam logic [CNT_W:0]   SUM_MAX  = (CNT_W + 1)'(MAX_REQUESTS);

  entry_t            ent_mem [MAX_REQUESTS];
  logic [IDX_W-1:0]  fifo_mem [MAX_REQUESTS];

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        p_r, p_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]        fill_r, fill_nxt;
  logic [MAX_REQUESTS-1:0] mark_r, mark_nxt;
  logic                    running_r, running_nxt;
  logic                    txrdy_r, txrdy_nxt;
  logic                    out_valid_r, out_valid_nxt;

  entry_t            new_r;
  entry_t            ent_rd_r;
  logic [IDX_W-1:0]  fifo_rd_r;
  logic              out_kind_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_wait_r;

  logic [IDX_W-1:0]    p_idx;
  logic [CNT_W-1:0]    p_m1;
  logic [IDX_W-1:0]    rd_addr;
  logic                ent_re;
  logic                ent_we;
  entry_t              ent_wd;
  logic [CNT_W:0]      tail_sum;
  logic [CNT_W:0]      tail_wrap;
  logic [IDX_W-1:0]    tail_idx;
  logic [IDX_W-1:0]    head_inc;
  logic [PERIOD_W-1:0] period_clamped;
  logic                expired;
  logic                append;

  assign p_idx    = p_r[IDX_W-1:0];
  assign p_m1     = p_r - 1'b1;
  assign tail_sum = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(fill_r);
  assign tail_wrap = tail_sum - SUM_MAX;
  assign tail_idx = (tail_sum >= SUM_MAX) ? tail_wrap[IDX_W-1:0] : tail_sum[IDX_W-1:0];
  assign head_inc = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
  assign period_clamped = (new_period < PERIOD_FLOOR) ? PERIOD_FLOOR : new_period;
  assign expired  = (ent_rd_r.countdown <= 16'd1);
  assign append   = cmd.wr_tick && expired && !mark_r[p_idx] && (fill_r != CNT_MAX);

  // Entry read address and write data.
  always_comb begin
    ent_re  = cmd.rd_p | cmd.rd_pm1 | cmd.rd_fifo;
    rd_addr = p_idx;
    if (cmd.rd_pm1) begin
      rd_addr = p_m1[IDX_W-1:0];
    end else if (cmd.rd_fifo) begin
      rd_addr = fifo_rd_r;
    end
    ent_we = cmd.wr_new | cmd.wr_shift | cmd.wr_reload | cmd.wr_tick;
    ent_wd = ent_rd_r;
    if (cmd.wr_new) begin
      ent_wd = new_r;
    end else if (cmd.wr_reload) begin
      ent_wd.countdown = ent_rd_r.period;
    end else if (cmd.wr_tick) begin
      ent_wd.countdown = expired ? ent_rd_r.period : ent_rd_r.countdown - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[p_idx] <= ent_wd;
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      fifo_mem[tail_idx] <= p_idx;
    end
    if (cmd.fifo_rd) begin
      fifo_rd_r <= fifo_mem[head_r];
    end
  end

  always_comb begin
    count_nxt     = count_r;
    p_nxt         = p_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    mark_nxt      = mark_r;
    running_nxt   = running_r;
    txrdy_nxt     = txrdy_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.count_zero) begin
      count_nxt = '0;
    end else if (cmd.count_inc) begin
      count_nxt = count_r + 1'b1;
    end

    if (cmd.load_new) begin
      p_nxt = count_r;
    end else if (cmd.p_zero) begin
      p_nxt = '0;
    end else if (cmd.p_dec) begin
      p_nxt = p_m1;
    end else if (cmd.p_inc) begin
      p_nxt = p_r + 1'b1;
    end

    if (cmd.queue_clear) begin
      head_nxt = '0;
      fill_nxt = '0;
      mark_nxt = '0;
    end else if (append) begin
      fill_nxt        = fill_r + 1'b1;
      mark_nxt[p_idx] = 1'b1;
    end else if (cmd.out_tx) begin
      head_nxt            = head_inc;
      fill_nxt            = fill_r - 1'b1;
      mark_nxt[fifo_rd_r] = 1'b0;
    end

    if (cmd.run_set) begin
      running_nxt = 1'b1;
    end else if (cmd.run_clr) begin
      running_nxt = 1'b0;
    end

    if (cmd.ready_set) begin
      txrdy_nxt = 1'b1;
    end else if (cmd.out_tx) begin
      txrdy_nxt = 1'b0;
    end

    if (cmd.out_tx || cmd.out_rej) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      p_r         <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      mark_r      <= '0;
      running_r   <= 1'b0;
      txrdy_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      p_r         <= p_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      mark_r      <= mark_nxt;
      running_r   <= running_nxt;
      txrdy_r     <= txrdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_new) begin
      new_r.tag        <= new_tag;
      new_r.period     <= period_clamped;
      new_r.reply_flag <= new_wait;
      new_r.countdown  <= period_clamped;
    end
    if (cmd.out_tx) begin
      out_kind_r <= EV_SENT;
      out_tag_r  <= ent_rd_r.tag;
      out_wait_r <= ent_rd_r.reply_flag;
    end else if (cmd.out_rej) begin
      out_kind_r <= EV_REJECT;
      out_tag_r  <= '0;
      out_wait_r <= 1'b0;
    end
  end

  assign sts.p_zero     = (p_r == '0);
  assign sts.p_at_count = (p_r == count_r);
  assign sts.full       = (count_r == CNT_MAX);
  assign sts.shift_go   = (ent_rd_r.period <= new_r.period);
  assign sts.can_tx     = running_r && txrdy_r && (fill_r != '0);
  assign sts.running    = running_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_kind_r;
  assign out_sent_tag        = out_tag_r;
  assign out_sent_reply_flag = out_wait_r;

endmodule

[rtl/prps_ctrl.sv]
// Controller: sequences list insertion, countdown passes and transmission.
module prps_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [prps_pkg::OPC_W-1:0] in_opcode,
  input  prps_pkg::dp_sts_t          sts,
  output prps_pkg::dp_cmd_t          cmd
);
  import prps_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SHIFT_RD = 11'b000_0000_0010,
    S_SHIFT_WR = 11'b000_0000_0100,
    S_RST_RD   = 11'b000_0000_1000,
    S_RST_WR   = 11'b000_0001_0000,
    S_TICK_RD  = 11'b000_0010_0000,
    S_TICK_WR  = 11'b000_0100_0000,
    S_TX_CHK   = 11'b000_1000_0000,
    S_TX_FIFO  = 11'b001_0000_0000,
    S_EMIT_TX  = 11'b010_0000_0000,
    S_EMIT_REJ = 11'b100_0000_0000
  } state_t;

  state_t  state_r, state_nxt;
  opcode_t opc;

  assign opc      = opcode_t'(in_opcode);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (opc)
            OP_ADD: begin
              if (sts.full) begin
                state_nxt = S_EMIT_REJ;
              end else begin
                cmd.load_new  = 1'b1;
                cmd.count_inc = 1'b1;
                state_nxt     = S_SHIFT_RD;
              end
            end
            OP_TICK: begin
              if (sts.running) begin
                cmd.p_zero = 1'b1;
                state_nxt  = S_TICK_RD;
              end
            end
            OP_TXDONE: begin
              cmd.ready_set = 1'b1;
              state_nxt     = S_TX_CHK;
            end
            OP_STOP: begin
              cmd.queue_clear = 1'b1;
              cmd.run_clr     = 1'b1;
            end
            OP_CLEAR: begin
              cmd.queue_clear = 1'b1;
              cmd.run_clr     = 1'b1;
              cmd.count_zero  = 1'b1;
            end
            OP_START: begin
              cmd.queue_clear = 1'b1;
              cmd.run_set     = 1'b1;
              cmd.p_zero      = 1'b1;
              state_nxt       = S_RST_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (sts.p_zero) begin
          cmd.wr_new      = 1'b1;
          cmd.queue_clear = 1'b1;
          cmd.run_set     = 1'b1;
          cmd.p_zero      = 1'b1;
          state_nxt       = S_RST_RD;
        end else begin
          cmd.rd_pm1 = 1'b1;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        if (sts.shift_go) begin
          cmd.wr_shift = 1'b1;
          cmd.p_dec    = 1'b1;
          state_nxt    = S_SHIFT_RD;
        end else begin
          cmd.wr_new      = 1'b1;
          cmd.queue_clear = 1'b1;
          cmd.run_set     = 1'b1;
          cmd.p_zero      = 1'b1;
          state_nxt       = S_RST_RD;
        end
      end
      S_RST_RD: begin
        if (sts.p_at_count) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_p  = 1'b1;
          state_nxt = S_RST_WR;
        end
      end
      S_RST_WR: begin
        cmd.wr_reload = 1'b1;
        cmd.p_inc     = 1'b1;
        state_nxt     = S_RST_RD;
      end
      S_TICK_RD: begin
        if (sts.p_at_count) begin
          state_nxt = S_TX_CHK;
        end else begin
          cmd.rd_p  = 1'b1;
          state_nxt = S_TICK_WR;
        end
      end
      S_TICK_WR: begin
        cmd.wr_tick = 1'b1;
        cmd.p_inc   = 1'b1;
        state_nxt   = S_TICK_RD;
      end
      S_TX_CHK: begin
        if (sts.can_tx) begin
          cmd.fifo_rd = 1'b1;
          state_nxt   = S_TX_FIFO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TX_FIFO: begin
        cmd.rd_fifo = 1'b1;
        state_nxt   = S_EMIT_TX;
      end
      S_EMIT_TX: begin
        if (sts.out_free) begin
          cmd.out_tx = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_EMIT_REJ: begin
        if (sts.out_free) begin
          cmd.out_rej = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/periodic_request_poll_scheduler_unit.sv]
// Top level of the periodic request poll scheduler.
// The scheduler holds up to MAX_REQUESTS periodic requests in a list ordered by
// descending period, where a new request goes ahead of older ones with the same
// period and periods below five ticks are raised to five. Each input transfer is
// a command: add, tick, transmit done, stop, clear all or start. An add, or a
// start, reloads every countdown, empties the pending queue and enters run; a
// tick counts every request down in list order and queues each expired one that
// is not already pending; while running, the oldest pending request is sent
// whenever the transmitter is free, and transmit done frees it again. An add to a
// full list produces a reject event instead. The block works on one command at a
// time, and every request list access goes through a single-port memory with a
// registered read, so a pass over the list takes a read state and a write state
// for each stored request. Stop, clear all, the unused codes and a tick while
// stopped make no pass. A tick in run makes one countdown pass and then checks
// whether to send a request. An add first moves entries down to open a gap in
// the list and then makes a reload pass over the countdowns; an add to a full
// list only emits a reject; start makes a reload pass. Transmit done checks
// whether to send. A finished event waits in an output register, so the next
// command is taken while the previous event has not been collected; the block
// only stalls when a second event is ready before the first is taken.
module periodic_request_poll_scheduler_unit #(
  parameter int unsigned MAX_REQUESTS = prps_pkg::MAX_REQUESTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  prps_in_if.sink    in_chan,
  prps_out_if.source out_chan
);
  import prps_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns the input handshake; the datapath owns the output
  // register, so a waiting event stalls input only if a second event is ready.
  prps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_opcode (in_chan.opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath keeps the request list, the pending queue with its per-request
  // pending marks, the run and transmitter-ready flags and the event register.
  prps_dp #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .new_tag             (in_chan.request_tag),
    .new_period          (in_chan.period_ticks),
    .new_wait            (in_chan.reply_flag),
    .out_ready           (out_chan.ready),
    .out_valid           (out_chan.valid),
    .out_event_kind      (out_chan.event_kind),
    .out_sent_tag        (out_chan.sent_tag),
    .out_sent_reply_flag (out_chan.sent_reply_flag)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the periodic request poll scheduler unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prps_pkg::*;

  localparam int NREQ   = MAX_REQUESTS_DEF;
  localparam int SLOT_W = $clog2(NREQ);

  // Opcodes six and seven are not defined by the block and must do nothing.
  localparam logic [OPC_W-1:0] OPC_SPARE6 = 3'd6;
  localparam logic [OPC_W-1:0] OPC_SPARE7 = 3'd7;

  // The quiet tail after the last result outlasts the slowest command (an add
  // into a list of seven), so it covers any late event.
  localparam int TAIL_CYCLES = 100;
  localparam int CYCLE_LIMIT = 1_000_000;

  // One event as the block reports it on the result channel.
  typedef struct packed {
    logic             kind;
    logic [TAG_W-1:0] tag;
    logic             reply_flag;
  } sched_event_t;

  logic clk;
  logic rst_n;

  prps_in_if  in_chan ();
  prps_out_if out_chan ();

  periodic_request_poll_scheduler_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scheduler prediction. The testbench keeps its own copy of the request list,
  // the pending queue and the run and transmitter flags, and advances it by one
  // command at every accepted input transfer.
  // ---------------------------------------------------------------------------
  logic [TAG_W-1:0]    rq_tag    [NREQ];
  logic [PERIOD_W-1:0] rq_period [NREQ];
  logic [PERIOD_W-1:0] rq_cdown  [NREQ];
  logic                rq_wait   [NREQ];
  logic [SLOT_W-1:0]   rq_order  [NREQ];
  int                  rq_count;
  logic [SLOT_W-1:0]   pend_slot [NREQ];
  logic                pend_mark [NREQ];
  int                  pend_head;
  int                  pend_fill;
  bit                  sched_running;
  bit                  tx_free;

  // Events the block still owes, oldest first.
  sched_event_t due_events[$];

  int err_count;
  int cycle_count;
  int n_commands;
  int n_effective;
  int n_sent;
  int n_rejected;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  function automatic void empty_pending();
    for (int i = 0; i < NREQ; i++) pend_mark[i] = 1'b0;
    pend_head = 0;
    pend_fill = 0;
  endfunction

  // Add and start both reload every countdown, drop the queue and enter run.
  function automatic void reload_and_run();
    for (int s = 0; s < rq_count; s++) rq_cdown[s] = rq_period[s];
    empty_pending();
    sched_running = 1'b1;
  endfunction

  function automatic bit pop_transmit(output sched_event_t ev);
    logic [SLOT_W-1:0] s;
    if (!sched_running || !tx_free || pend_fill == 0) return 1'b0;
    s = pend_slot[pend_head];
    pend_head = (pend_head + 1) % NREQ;
    pend_fill--;
    pend_mark[s] = 1'b0;
    tx_free = 1'b0;
    ev = '{kind: EV_SENT, tag: rq_tag[s], reply_flag: rq_wait[s]};
    return 1'b1;
  endfunction

  function automatic void insert_request(input logic [TAG_W-1:0] tag,
                                         input logic [PERIOD_W-1:0] per,
                                         input logic w);
    logic [PERIOD_W-1:0] p;
    int pos;
    p = (per < PERIOD_FLOOR) ? PERIOD_FLOOR : per;
    rq_tag[rq_count]    = tag;
    rq_period[rq_count] = p;
    rq_wait[rq_count]   = w;
    // A newer request goes ahead of older ones with an equal period.
    pos = 0;
    while (pos < rq_count && rq_period[rq_order[pos]] > p) pos++;
    for (int i = rq_count; i > pos; i--) rq_order[i] = rq_order[i-1];
    rq_order[pos] = SLOT_W'(rq_count);
    rq_count++;
  endfunction

  function automatic void count_down_all();
    logic [SLOT_W-1:0] s;
    for (int pos = 0; pos < rq_count; pos++) begin
      s = rq_order[pos];
      if (rq_cdown[s] <= 1) begin
        rq_cdown[s] = rq_period[s];
        if (!pend_mark[s] && pend_fill < NREQ) begin
          pend_slot[(pend_head + pend_fill) % NREQ] = s;
          pend_fill++;
          pend_mark[s] = 1'b1;
        end
      end else begin
        rq_cdown[s] = rq_cdown[s] - 1'b1;
      end
    end
  endfunction

  // Applies one command and queues the event it causes, if any.
  function automatic void schedule_command(input logic [OPC_W-1:0] op,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [PERIOD_W-1:0] per,
                                           input logic w);
    sched_event_t ev;
    bit fired;
    fired = 1'b0;
    n_effective++;
    case (op)
      OP_ADD: begin
        if (rq_count >= NREQ) begin
          ev = '{kind: EV_REJECT, tag: '0, reply_flag: 1'b0};
          fired = 1'b1;
        end else begin
          insert_request(tag, per, w);
          reload_and_run();
        end
      end
      OP_TICK: begin
        if (sched_running) begin
          count_down_all();
          fired = pop_transmit(ev);
        end else begin
          n_effective--;
        end
      end
      OP_TXDONE: begin
        tx_free = 1'b1;
        fired = pop_transmit(ev);
      end
      OP_STOP: begin
        empty_pending();
        sched_running = 1'b0;
      end
      OP_CLEAR: begin
        empty_pending();
        sched_running = 1'b0;
        rq_count = 0;
      end
      OP_START: reload_and_run();
      default: n_effective--;
    endcase
    if (fired) due_events.insert(due_events.size(), ev);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Fields change at the falling edge; a transfer is taken at the
  // rising edge with valid and ready both high. Valid stays high from one item
  // to the next unless the idle draw says otherwise, so each falling edge sees
  // at most one assignment to it.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [OPC_W-1:0] op,
                          input logic [TAG_W-1:0] tag,
                          input logic [PERIOD_W-1:0] per,
                          input logic w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.opcode       <= op;
    in_chan.request_tag  <= tag;
    in_chan.period_ticks <= per;
    in_chan.reply_flag   <= w;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    n_commands++;
    schedule_command(op, tag, per, w);
  endtask

  // Control commands carry random junk in the fields they do not use.
  task automatic send_op(input logic [OPC_W-1:0] op);
    send_cmd(op, TAG_W'($urandom), PERIOD_W'($urandom), 1'($urandom_range(1)));
  endtask

  function automatic logic [PERIOD_W-1:0] rand_period();
    int r;
    r = $urandom_range(99);
    // Mostly short periods so that requests expire often; some long ones so
    // that every period bit is exercised.
    if (r < 85) return PERIOD_W'($urandom_range(14));
    if (r < 95) return PERIOD_W'($urandom_range(60, 15));
    return PERIOD_W'($urandom);
  endfunction

  task automatic send_random_add();
    send_cmd(OP_ADD, TAG_W'($urandom), rand_period(), 1'($urandom_range(1)));
  endtask

  // Lowers valid and waits until every owed event has been collected.
  task automatic drain_events();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side. Ready is redrawn at every falling edge, except during a long
  // hold-off, which this process counts down itself.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    sched_event_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due_events.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result: expected none, actual kind=%0d tag=%h wait=%0d",
                 $time, out_chan.event_kind, out_chan.sent_tag, out_chan.sent_reply_flag);
      end else begin
        want = due_events.pop_front();
        if (want.kind == EV_SENT) n_sent++;
        else n_rejected++;
        if (out_chan.event_kind !== want.kind) begin
          err_count++;
          $display("%0t: event_kind mismatch: expected %0d, actual %0d",
                   $time, want.kind, out_chan.event_kind);
        end
        if (out_chan.sent_tag !== want.tag) begin
          err_count++;
          $display("%0t: sent_tag mismatch: expected %h, actual %h",
                   $time, want.tag, out_chan.sent_tag);
        end
        if (out_chan.sent_reply_flag !== want.reply_flag) begin
          err_count++;
          $display("%0t: sent_reply_flag mismatch: expected %0d, actual %0d",
                   $time, want.reply_flag, out_chan.sent_reply_flag);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d events still owed",
               $time, cycle_count, due_events.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Commands that find nothing to do: tick and transmit done while stopped, the
  // unused opcodes, and start and tick with an empty list.
  task automatic test_idle_commands();
    send_op(OP_TICK);
    send_op(OP_TXDONE);
    send_op(OPC_SPARE6);
    send_op(OPC_SPARE7);
    send_op(OP_START);
    send_op(OP_TICK);
  endtask

  // Period floor, field extremes and list order. After five ticks the three
  // requests with period five expire together and go out newest first; stop
  // then drops the one still pending.
  task automatic test_list_order();
    send_cmd(OP_ADD, 16'h0000, 16'd0, 1'b0);
    send_cmd(OP_ADD, 16'hFFFF, 16'd4, 1'b1);
    send_cmd(OP_ADD, 16'h1234, 16'd5, 1'b1);
    send_cmd(OP_ADD, 16'hABCD, 16'hFFFF, 1'b0);
    send_cmd(OP_ADD, 16'h5555, 16'd6, 1'b1);
    repeat (5) send_op(OP_TICK);
    send_op(OP_TXDONE);
    send_op(OP_STOP);
    send_op(OP_TXDONE);
  endtask

  // Fill the list to capacity, then an add is rejected; clear empties it.
  task automatic test_full_table();
    send_op(OP_START);
    send_cmd(OP_ADD, 16'h8001, 16'd7, 1'b0);
    send_cmd(OP_ADD, 16'h7FFE, 16'd7, 1'b1);
    send_cmd(OP_ADD, 16'h00FF, 16'd9, 1'b0);
    send_cmd(OP_ADD, 16'hFF00, 16'd3, 1'b1);
    send_op(OP_CLEAR);
  endtask

  // The receiver holds off for a long stretch while ticks and transmit-done
  // commands keep coming, so the output register fills and input stalls.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(OP_CLEAR);
    repeat (4) send_cmd(OP_ADD, TAG_W'($urandom), 16'd5, 1'($urandom_range(1)));
    hold_left = 400;
    repeat (20) begin
      send_op(OP_TICK);
      send_op(OP_TICK);
      send_op(OP_TXDONE);
    end
    drain_events();
  endtask

  // Random traffic: each round optionally clears or stops, loads a few requests
  // and then runs a burst of ticks and transmit completions, with a small share
  // of stops, starts, adds, clears and unused codes mixed in.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int goal;
    int r;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = n_effective + n_items;
    while (n_effective < goal) begin
      r = $urandom_range(99);
      if (r < 35) send_op(OP_CLEAR);
      else if (r < 45) send_op(OP_STOP);
      repeat ($urandom_range(5, 1)) send_random_add();
      repeat ($urandom_range(40, 8)) begin
        r = $urandom_range(99);
        if (r < 55)      send_op(OP_TICK);
        else if (r < 85) send_op(OP_TXDONE);
        else if (r < 88) send_op(OP_STOP);
        else if (r < 92) send_op(OP_START);
        else if (r < 94) send_op($urandom_range(1) ? OPC_SPARE6 : OPC_SPARE7);
        else if (r < 97) send_random_add();
        else             send_op(OP_CLEAR);
      end
    end
    drain_events();
  endtask

  initial begin
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.opcode       = OP_STOP;
    in_chan.request_tag  = '0;
    in_chan.period_ticks = '0;
    in_chan.reply_flag   = 1'b0;
    out_chan.ready       = 1'b0;
    err_count      = 0;
    cycle_count    = 0;
    n_commands     = 0;
    n_effective    = 0;
    n_sent         = 0;
    n_rejected     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    rq_count       = 0;
    sched_running  = 1'b0;
    tx_free        = 1'b1;
    empty_pending();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_commands();
    test_list_order();
    test_full_table();
    drain_events();
    test_output_backpressure();
    test_random_traffic(0, 0, 480);
    test_random_traffic(75, 0, 480);
    test_random_traffic(0, 75, 480);
    test_random_traffic(28, 28, 480);

    if (due_events.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected events never arrived", $time, due_events.size());
    end
    $display("Ran %0d commands (%0d with an effect) in four idle/stall mixes",
             n_commands, n_effective);
    $display("plus one long output hold-off; checked %0d transmissions and %0d rejects.",
             n_sent, n_rejected);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
